// ===== hdl/trtp_pkg.sv =====
// trtp_pkg: shared types, codes and constants of the transition rule text parser
// used by trtp_front, trtp_back, transition_rule_text_parser and the testbench
// no dependencies
package trtp_pkg;

    // default widths of the internal number registers
    localparam int STATE_BITS_DEF = 16;
    localparam int MOVE_BITS_DEF  = 16;

    // depth of the queues between the parts
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OPEN  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLOSE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEP   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONN  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK0 = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK1 = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK2 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK3 = 3'd7;

    // register reset values
    localparam logic [7:0] OPEN_RST  = 8'd40;
    localparam logic [7:0] CLOSE_RST = 8'd41;
    localparam logic [7:0] SEP_RST   = 8'd44;
    localparam logic [7:0] CONN_RST  = 8'd62;

    // fixed character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    // result kinds
    localparam logic [1:0] KIND_RULE  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // target kinds
    localparam logic [1:0] TGT_NUM    = 2'd0;
    localparam logic [1:0] TGT_ACCEPT = 2'd1;
    localparam logic [1:0] TGT_REJECT = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
    localparam logic [2:0] ERR_NO_LETTER = 3'd2;
    localparam logic [2:0] ERR_NO_SEP    = 3'd3;
    localparam logic [2:0] ERR_BAD_SYM   = 3'd4;
    localparam logic [2:0] ERR_NO_CLOSE  = 3'd5;
    localparam logic [2:0] ERR_NO_CONN   = 3'd6;
    localparam logic [2:0] ERR_EARLY_END = 3'd7;

    // one classified character, front to back
    typedef struct packed {
        logic       eot;
        logic       newline;
        logic       letter;
        logic       digit;
        logic [3:0] dval;
        logic       plus;
        logic       minus;
        logic       opn;
        logic       cls;
        logic       sep;
        logic       conn;
        logic       alpha;
        logic [7:0] ch;
    } class_t;

    // queue status and head item between front and back
    typedef struct packed {
        logic   valid;
        class_t item;
    } class_port_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] from_state;
        logic [7:0]  read_symbol;
        logic [15:0] to_state;
        logic [1:0]  target_kind;
        logic [7:0]  write_symbol;
        logic [15:0] head_move;
        logic [2:0]  error_code;
        logic [15:0] error_position;
    } result_t;

endpackage

// ===== hdl/trtp_fifo.sv =====
// trtp_fifo: small first-in first-out queue of flip-flop entries
// used by trtp_front and trtp_back; no package dependency
module trtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // status and transfer qualifiers
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/trtp_front.sv =====
// trtp_front: configuration registers, character classification and the class queue
// depends on trtp_pkg and trtp_fifo
module trtp_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            ch,
    input  logic                                  end_of_text,
    input  logic                                  wr_en,
    input  logic [trtp_pkg::CFG_INDEX_BITS-1:0]   wr_index,
    input  logic [trtp_pkg::CFG_DATA_BITS-1:0]    wr_data,
    output trtp_pkg::class_port_t                 cls_out,
    input  logic                                  cls_pop
);

    logic [7:0]  open_reg;
    logic [7:0]  close_reg;
    logic [7:0]  sep_reg;
    logic [7:0]  conn_reg;
    logic [63:0] mask0_reg;
    logic [63:0] mask1_reg;
    logic [63:0] mask2_reg;
    logic [63:0] mask3_reg;
    logic [63:0] mask_sel;
    logic [7:0]  dig_off;
    trtp_pkg::class_t cls;
    trtp_pkg::class_t q_item;
    logic             q_empty;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= trtp_pkg::OPEN_RST;
            close_reg <= trtp_pkg::CLOSE_RST;
            sep_reg   <= trtp_pkg::SEP_RST;
            conn_reg  <= trtp_pkg::CONN_RST;
            mask0_reg <= '0;
            mask1_reg <= '0;
            mask2_reg <= '0;
            mask3_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                trtp_pkg::REG_OPEN:  open_reg  <= wr_data[7:0];
                trtp_pkg::REG_CLOSE: close_reg <= wr_data[7:0];
                trtp_pkg::REG_SEP:   sep_reg   <= wr_data[7:0];
                trtp_pkg::REG_CONN:  conn_reg  <= wr_data[7:0];
                trtp_pkg::REG_MASK0: mask0_reg <= wr_data;
                trtp_pkg::REG_MASK1: mask1_reg <= wr_data;
                trtp_pkg::REG_MASK2: mask2_reg <= wr_data;
                trtp_pkg::REG_MASK3: mask3_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // alphabet mask word for the upper two bits of the character
    always_comb
    begin
        case (ch[7:6])
            2'd0:    mask_sel = mask0_reg;
            2'd1:    mask_sel = mask1_reg;
            2'd2:    mask_sel = mask2_reg;
            default: mask_sel = mask3_reg;
        endcase
    end

    // classify the incoming character
    assign dig_off = ch - trtp_pkg::CHAR_ZERO;

    always_comb
    begin
        cls.eot     = end_of_text;
        cls.newline = (ch == trtp_pkg::CHAR_NEWLINE);
        cls.letter  = (ch >= trtp_pkg::CHAR_UPPER_A && ch <= trtp_pkg::CHAR_UPPER_Z) ||
                      (ch >= trtp_pkg::CHAR_LOWER_A && ch <= trtp_pkg::CHAR_LOWER_Z);
        cls.digit   = (ch >= trtp_pkg::CHAR_ZERO && ch <= trtp_pkg::CHAR_NINE);
        cls.dval    = dig_off[3:0];
        cls.plus    = (ch == trtp_pkg::CHAR_PLUS);
        cls.minus   = (ch == trtp_pkg::CHAR_MINUS);
        cls.opn     = (ch == open_reg);
        cls.cls     = (ch == close_reg);
        cls.sep     = (ch == sep_reg);
        cls.conn    = (ch == conn_reg);
        cls.alpha   = mask_sel[ch[5:0]];
        cls.ch      = ch;
    end

    // queue of classified characters toward the parser
    trtp_fifo #(
        .WIDTH ($bits(trtp_pkg::class_t)),
        .DEPTH (trtp_pkg::QUEUE_DEPTH)
    ) u_class_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (cls_pop),
        .rdata (q_item),
        .empty (q_empty)
    );

    assign cls_out.valid = !q_empty;
    assign cls_out.item  = q_item;

endmodule

// ===== hdl/trtp_back.sv =====
// trtp_back: parse state machine, number accumulators and the result queue
// depends on trtp_pkg and trtp_fifo
module trtp_back #(
    parameter int STATE_BITS = trtp_pkg::STATE_BITS_DEF,
    parameter int MOVE_BITS  = trtp_pkg::MOVE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trtp_pkg::class_port_t cls_in,
    output logic                  cls_pop,
    output logic                  empty,
    input  logic                  pop,
    output trtp_pkg::result_t     res_out
);

    localparam int SW = STATE_BITS;
    localparam int MW = MOVE_BITS - 1;

    // parse phases
    localparam logic [3:0] PH_OPEN        = 4'd0;
    localparam logic [3:0] PH_FROM_LETTER = 4'd1;
    localparam logic [3:0] PH_FROM_NUM    = 4'd2;
    localparam logic [3:0] PH_READ_SYM    = 4'd3;
    localparam logic [3:0] PH_CLOSE       = 4'd4;
    localparam logic [3:0] PH_CONN        = 4'd5;
    localparam logic [3:0] PH_OPEN2       = 4'd6;
    localparam logic [3:0] PH_TO_LETTER   = 4'd7;
    localparam logic [3:0] PH_TO_NUM      = 4'd8;
    localparam logic [3:0] PH_WRITE_SYM   = 4'd9;
    localparam logic [3:0] PH_SEP2        = 4'd10;
    localparam logic [3:0] PH_MOVE        = 4'd11;
    localparam logic [3:0] PH_END         = 4'd12;

    trtp_pkg::class_t it;

    logic [3:0]    phase_reg, phase_next;
    logic          failed_reg, failed_next;
    logic [SW-1:0] from_reg, from_next;
    logic [SW-1:0] to_reg, to_next;
    logic [1:0]    tgt_reg, tgt_next;
    logic [7:0]    rsym_reg, rsym_next;
    logic [7:0]    wsym_reg, wsym_next;
    logic [MW-1:0] mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [15:0]   pos_reg, pos_next;
    logic [15:0]   pos_inc;

    logic [SW-1:0] st_acc_in;
    logic [SW+3:0] st_prod;
    logic [SW-1:0] st_acc;
    logic [MW+3:0] mv_prod;
    logic [MW-1:0] mv_acc;
    logic [31:0]   from_wide;
    logic [31:0]   to_wide;
    logic [31:0]   mv_wide;
    logic [31:0]   mv_signed;

    logic          take;
    logic          out_full;
    logic          emit_rule;
    logic          emit_err;
    logic          emit_done;
    logic [2:0]    err_code;
    logic [15:0]   err_pos;
    logic          clr_rule;
    logic          clr_text;
    trtp_pkg::result_t res;

    assign it      = cls_in.item;
    assign take    = cls_in.valid && !out_full;
    assign cls_pop = take;
    assign pos_inc = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;

    // times-ten accumulate, saturating when the product leaves the register width
    assign st_acc_in = (phase_reg == PH_TO_NUM) ? to_reg : from_reg;
    assign st_prod   = ((SW+4)'(st_acc_in) << 3) + ((SW+4)'(st_acc_in) << 1) +
                       (SW+4)'(it.dval);
    assign st_acc    = (st_prod[SW+3:SW] != 4'd0) ? '1 : st_prod[SW-1:0];
    assign mv_prod   = ((MW+4)'(mag_reg) << 3) + ((MW+4)'(mag_reg) << 1) +
                       (MW+4)'(it.dval);
    assign mv_acc    = (mv_prod[MW+3:MW] != 4'd0) ? '1 : mv_prod[MW-1:0];

    // parse step
    always_comb
    begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        tgt_next    = tgt_reg;
        rsym_next   = rsym_reg;
        wsym_next   = wsym_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        pos_next    = pos_reg;
        emit_rule   = 1'b0;
        emit_err    = 1'b0;
        emit_done   = 1'b0;
        err_code    = trtp_pkg::ERR_NONE;
        err_pos     = pos_inc;
        clr_rule    = 1'b0;
        clr_text    = 1'b0;

        if (take)
        begin
            if (it.eot)
            begin
                // end of text closes the rule, finishes or reports an early end; silent after an error
                clr_text = 1'b1;
                if (!failed_reg)
                begin
                    if (phase_reg == PH_END)
                    begin
                        emit_rule = 1'b1;
                    end
                    else if (phase_reg == PH_OPEN || phase_reg > PH_END)
                    begin
                        emit_done = 1'b1;
                    end
                    else
                    begin
                        emit_err = 1'b1;
                        err_code = trtp_pkg::ERR_EARLY_END;
                        err_pos  = pos_reg;
                    end
                end
            end
            else if (!it.newline)
            begin
                pos_next = pos_inc;
                if (!failed_reg)
                begin
                    case (phase_reg) inside
                        PH_FROM_LETTER, PH_TO_LETTER:
                        begin
                            if (it.letter)
                                phase_next = phase_reg + 4'd1;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_LETTER;
                            end
                        end
                        PH_FROM_NUM:
                        begin
                            if (it.digit)
                                from_next = st_acc;
                            else if (it.sep)
                                phase_next = PH_READ_SYM;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_SEP;
                            end
                        end
                        PH_READ_SYM, PH_WRITE_SYM:
                        begin
                            if (it.alpha)
                            begin
                                if (phase_reg == PH_READ_SYM)
                                    rsym_next = it.ch;
                                else
                                    wsym_next = it.ch;
                                phase_next = phase_reg + 4'd1;
                            end
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_BAD_SYM;
                            end
                        end
                        PH_CLOSE:
                        begin
                            if (it.cls)
                                phase_next = PH_CONN;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_CLOSE;
                            end
                        end
                        PH_CONN:
                        begin
                            if (it.conn)
                                phase_next = PH_OPEN2;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_CONN;
                            end
                        end
                        PH_OPEN2:
                        begin
                            if (it.opn)
                                phase_next = PH_TO_LETTER;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_OPEN;
                            end
                        end
                        PH_TO_NUM:
                        begin
                            // a mark is taken only while the number is still zero and no mark is set
                            if (tgt_reg == trtp_pkg::TGT_NUM && to_reg == '0 && it.plus)
                                tgt_next = trtp_pkg::TGT_ACCEPT;
                            else if (tgt_reg == trtp_pkg::TGT_NUM && to_reg == '0 && it.minus)
                                tgt_next = trtp_pkg::TGT_REJECT;
                            else if (it.digit && tgt_reg == trtp_pkg::TGT_NUM)
                                to_next = st_acc;
                            else if (it.sep)
                                phase_next = PH_WRITE_SYM;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_SEP;
                            end
                        end
                        PH_SEP2:
                        begin
                            if (it.sep)
                                phase_next = PH_MOVE;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_SEP;
                            end
                        end
                        PH_MOVE:
                        begin
                            if (it.minus)
                                neg_next = 1'b1;
                            else if (it.digit)
                                mag_next = mv_acc;
                            else if (it.cls)
                                phase_next = PH_END;
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_CLOSE;
                            end
                        end
                        PH_END:
                        begin
                            if (it.sep)
                            begin
                                emit_rule  = 1'b1;
                                clr_rule   = 1'b1;
                                phase_next = PH_OPEN;
                            end
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_SEP;
                            end
                        end
                        default:
                        begin
                            // waiting for the opening character, also unused codes
                            if (it.opn)
                            begin
                                clr_rule   = 1'b1;
                                phase_next = PH_FROM_LETTER;
                            end
                            else
                            begin
                                emit_err = 1'b1;
                                err_code = trtp_pkg::ERR_NO_OPEN;
                            end
                        end
                    endcase
                    if (emit_err)
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
        end

        // clear the rule fields, and the whole text on its end
        if (clr_rule || clr_text)
        begin
            from_next = '0;
            to_next   = '0;
            tgt_next  = trtp_pkg::TGT_NUM;
            rsym_next = '0;
            wsym_next = '0;
            mag_next  = '0;
            neg_next  = 1'b0;
        end
        if (clr_text)
        begin
            phase_next  = PH_OPEN;
            failed_next = 1'b0;
            pos_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            failed_reg <= 1'b0;
            from_reg   <= '0;
            to_reg     <= '0;
            tgt_reg    <= trtp_pkg::TGT_NUM;
            rsym_reg   <= '0;
            wsym_reg   <= '0;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            failed_reg <= failed_next;
            from_reg   <= from_next;
            to_reg     <= to_next;
            tgt_reg    <= tgt_next;
            rsym_reg   <= rsym_next;
            wsym_reg   <= wsym_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            pos_reg    <= pos_next;
        end
    end

    // result record assembly
    assign from_wide = 32'(from_reg);
    assign to_wide   = 32'(to_reg);
    assign mv_wide   = 32'(mag_reg);
    assign mv_signed = neg_reg ? (32'd0 - mv_wide) : mv_wide;

    always_comb
    begin
        res = '0;
        if (emit_rule)
        begin
            res.kind         = trtp_pkg::KIND_RULE;
            res.from_state   = from_wide[15:0];
            res.read_symbol  = rsym_reg;
            res.to_state     = (tgt_reg != trtp_pkg::TGT_NUM) ? 16'd0 : to_wide[15:0];
            res.target_kind  = tgt_reg;
            res.write_symbol = wsym_reg;
            res.head_move    = mv_signed[15:0];
        end
        else if (emit_err)
        begin
            res.kind           = trtp_pkg::KIND_ERROR;
            res.error_code     = err_code;
            res.error_position = err_pos;
        end
        else
        begin
            res.kind = trtp_pkg::KIND_DONE;
        end
    end

    // result queue toward the consumer
    trtp_fifo #(
        .WIDTH ($bits(trtp_pkg::result_t)),
        .DEPTH (trtp_pkg::QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (emit_rule || emit_err || emit_done),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

endmodule

// ===== hdl/transition_rule_text_parser.sv =====
// transition_rule_text_parser: top level of the rule text parser
// depends on trtp_pkg, trtp_front and trtp_back
//
//   channel    handshake            payload
//   -------    ---------            -------
//   input      push / full          ch, end_of_text
//   result     empty / pop          kind .. error_position (nine fields)
//   config     wr_en (no wait)      wr_index, wr_data
//
// one character per cycle sustained while the result queue has room; the
// parser takes a new character every cycle from a two-entry class queue
// unless the result queue is full and writes at most one result into a
// two-entry result queue, so a result passes the class queue, then the result queue
// reset clears the parse state and both queues and loads register defaults
// full rises only when the class queue holds two characters the parser could
// not take because the result queue was full
module transition_rule_text_parser #(
    parameter int STATE_BITS = trtp_pkg::STATE_BITS_DEF,
    parameter int MOVE_BITS  = trtp_pkg::MOVE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          ch,
    input  logic                                end_of_text,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          kind,
    output logic [15:0]                         from_state,
    output logic [7:0]                          read_symbol,
    output logic [15:0]                         to_state,
    output logic [1:0]                          target_kind,
    output logic [7:0]                          write_symbol,
    output logic signed [15:0]                  head_move,
    output logic [2:0]                          error_code,
    output logic [15:0]                         error_position,
    input  logic                                wr_en,
    input  logic [trtp_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [trtp_pkg::CFG_DATA_BITS-1:0]  wr_data
);

    trtp_pkg::class_port_t cls_link;
    logic                  cls_pop;
    trtp_pkg::result_t     res;

    // front: registers, classification, class queue
    trtp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .end_of_text (end_of_text),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .cls_out     (cls_link),
        .cls_pop     (cls_pop)
    );

    // back: parser and result queue
    trtp_back #(
        .STATE_BITS (STATE_BITS),
        .MOVE_BITS  (MOVE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cls_in  (cls_link),
        .cls_pop (cls_pop),
        .empty   (empty),
        .pop     (pop),
        .res_out (res)
    );

    // result fields to ports
    assign kind           = res.kind;
    assign from_state     = res.from_state;
    assign read_symbol    = res.read_symbol;
    assign to_state       = res.to_state;
    assign target_kind    = res.target_kind;
    assign write_symbol   = res.write_symbol;
    assign head_move      = res.head_move;
    assign error_code     = res.error_code;
    assign error_position = res.error_position;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: checks transition_rule_text_parser against its own parser model, fed with
// rule texts of random content, broken texts, idling on both sides and register changes
// depends on trtp_pkg and transition_rule_text_parser
module testbench;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_CHARS  = 60;
    localparam int NUM_SETTINGS = 7;
    localparam int PRINT_CAP    = 40;
    localparam longint TIMEOUT_NS = 4_000_000;
    localparam longint unsigned STATE_TOP = (64'd1 << trtp_pkg::STATE_BITS_DEF) - 1;
    localparam longint unsigned MOVE_TOP  = (64'd1 << (trtp_pkg::MOVE_BITS_DEF - 1)) - 1;
    localparam logic [7:0] SYM_A = "a";
    localparam logic [7:0] SYM_B = "b";

    // parse phases of one rule
    typedef enum logic [3:0] {
        P_OPEN, P_LETTER1, P_FROM, P_READ, P_CLOSE1, P_CONN, P_OPEN2,
        P_LETTER2, P_TO, P_WRITE, P_SEP2, P_MOVE, P_RULE_DONE
    } parse_phase_e;

    // register settings walked through by the random part
    typedef enum int {
        SET_DEFAULT, SET_EXTREME, SET_BRACKETS, SET_PLUS_SEP,
        SET_DIGIT_MARKS, SET_RANDOM, SET_HIGH_SYMBOLS
    } char_setting_e;

    typedef struct packed {
        logic [7:0] code;
        logic       eot;
    } text_item_t;

    // block ports
    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                push = 1'b0;
    logic                                full;
    logic [7:0]                          ch = 8'd0;
    logic                                end_of_text = 1'b0;
    logic                                empty;
    logic                                pop = 1'b0;
    logic [1:0]                          kind;
    logic [15:0]                         from_state;
    logic [7:0]                          read_symbol;
    logic [15:0]                         to_state;
    logic [1:0]                          target_kind;
    logic [7:0]                          write_symbol;
    logic signed [15:0]                  head_move;
    logic [2:0]                          error_code;
    logic [15:0]                         error_position;
    logic                                wr_en = 1'b0;
    logic [trtp_pkg::CFG_INDEX_BITS-1:0] wr_index = '0;
    logic [trtp_pkg::CFG_DATA_BITS-1:0]  wr_data = '0;

    // register copy
    logic [7:0]  cfg_open, cfg_close, cfg_sep, cfg_conn;
    logic [63:0] cfg_alpha [4];

    // parser model state
    parse_phase_e parse_phase;
    logic         parse_failed;
    logic [15:0]  from_num, to_num, char_count;
    logic [1:0]   to_mark;
    logic [7:0]   read_sym, write_sym;
    logic [14:0]  move_mag;
    logic         move_neg;

    text_item_t        text_chars[$];
    text_item_t        text_buf[$];
    trtp_pkg::result_t parsed_records[$];
    int                mismatch_count = 0;
    bit                took = 1'b0;
    int                gap_left = 0, send_calm = 0, stall_left = 0, recv_calm = 0;

    transition_rule_text_parser dut (.*);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ---------------- parser model ----------------

    function automatic void clear_rule();
        from_num  = '0;
        to_num    = '0;
        to_mark   = trtp_pkg::TGT_NUM;
        read_sym  = '0;
        write_sym = '0;
        move_mag  = '0;
        move_neg  = 1'b0;
    endfunction

    function automatic void clear_text();
        parse_phase  = P_OPEN;
        parse_failed = 1'b0;
        char_count   = '0;
        clear_rule();
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= trtp_pkg::CHAR_UPPER_A && c <= trtp_pkg::CHAR_UPPER_Z) ||
               (c >= trtp_pkg::CHAR_LOWER_A && c <= trtp_pkg::CHAR_LOWER_Z);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= trtp_pkg::CHAR_ZERO && c <= trtp_pkg::CHAR_NINE;
    endfunction

    function automatic bit in_alphabet(input logic [7:0] c);
        return cfg_alpha[c[7:6]][c[5:0]];
    endfunction

    // decimal accumulate, saturating at top
    function automatic longint unsigned add_digit(input longint unsigned v,
                                                  input logic [7:0] c,
                                                  input longint unsigned top);
        longint unsigned d;
        d = 64'(c) - 64'(trtp_pkg::CHAR_ZERO);
        if (v > (top - d) / 10)
            return top;
        return v * 10 + d;
    endfunction

    function automatic trtp_pkg::result_t rule_record();
        trtp_pkg::result_t r;
        logic [15:0]       m;
        r = '0;
        m = {1'b0, move_mag};
        r.kind         = trtp_pkg::KIND_RULE;
        r.from_state   = from_num;
        r.read_symbol  = read_sym;
        r.to_state     = (to_mark == trtp_pkg::TGT_NUM) ? to_num : 16'd0;
        r.target_kind  = to_mark;
        r.write_symbol = write_sym;
        r.head_move    = move_neg ? 16'd0 - m : m;
        return r;
    endfunction

    function automatic trtp_pkg::result_t error_record(input logic [2:0] code);
        trtp_pkg::result_t r;
        r = '0;
        r.kind           = trtp_pkg::KIND_ERROR;
        r.error_code     = code;
        r.error_position = char_count;
        parse_failed     = 1'b1;
        return r;
    endfunction

    // one character (or end of text) through the parser
    task automatic parse_char(input logic [7:0] c, input logic eot,
                              output bit got, output trtp_pkg::result_t r);
        got = 1'b0;
        r   = '0;
        if (eot)
        begin
            if (parse_failed)
                got = 1'b0;
            else if (parse_phase == P_RULE_DONE)
            begin
                r = rule_record();
                got = 1'b1;
            end
            else if (parse_phase == P_OPEN)
            begin
                r.kind = trtp_pkg::KIND_DONE;
                got = 1'b1;
            end
            else
            begin
                r = error_record(trtp_pkg::ERR_EARLY_END);
                got = 1'b1;
            end
            clear_text();
        end
        else if (c != trtp_pkg::CHAR_NEWLINE)
        begin
            if (char_count != 16'hFFFF)
                char_count = char_count + 16'd1;
            if (!parse_failed)
            begin
                case (parse_phase)
                    P_LETTER1, P_LETTER2:
                    begin
                        if (!is_letter(c))
                        begin
                            r = error_record(trtp_pkg::ERR_NO_LETTER);
                            got = 1'b1;
                        end
                        else
                            parse_phase = (parse_phase == P_LETTER1) ? P_FROM : P_TO;
                    end
                    P_FROM:
                    begin
                        if (is_digit(c))
                            from_num = 16'(add_digit(from_num, c, STATE_TOP));
                        else if (c == cfg_sep)
                            parse_phase = P_READ;
                        else
                        begin
                            r = error_record(trtp_pkg::ERR_NO_SEP);
                            got = 1'b1;
                        end
                    end
                    P_READ:
                    begin
                        if (!in_alphabet(c))
                        begin
                            r = error_record(trtp_pkg::ERR_BAD_SYM);
                            got = 1'b1;
                        end
                        else
                        begin
                            read_sym = c;
                            parse_phase = P_CLOSE1;
                        end
                    end
                    P_CLOSE1:
                    begin
                        if (c != cfg_close)
                        begin
                            r = error_record(trtp_pkg::ERR_NO_CLOSE);
                            got = 1'b1;
                        end
                        else
                            parse_phase = P_CONN;
                    end
                    P_CONN:
                    begin
                        if (c != cfg_conn)
                        begin
                            r = error_record(trtp_pkg::ERR_NO_CONN);
                            got = 1'b1;
                        end
                        else
                            parse_phase = P_OPEN2;
                    end
                    P_OPEN2:
                    begin
                        if (c != cfg_open)
                        begin
                            r = error_record(trtp_pkg::ERR_NO_OPEN);
                            got = 1'b1;
                        end
                        else
                            parse_phase = P_LETTER2;
                    end
                    P_TO:
                    begin
                        // marks win over digits and the separator
                        if (to_mark == trtp_pkg::TGT_NUM && to_num == 0 &&
                            c == trtp_pkg::CHAR_PLUS)
                            to_mark = trtp_pkg::TGT_ACCEPT;
                        else if (to_mark == trtp_pkg::TGT_NUM && to_num == 0 &&
                                 c == trtp_pkg::CHAR_MINUS)
                            to_mark = trtp_pkg::TGT_REJECT;
                        else if (is_digit(c) && to_mark == trtp_pkg::TGT_NUM)
                            to_num = 16'(add_digit(to_num, c, STATE_TOP));
                        else if (c == cfg_sep)
                            parse_phase = P_WRITE;
                        else
                        begin
                            r = error_record(trtp_pkg::ERR_NO_SEP);
                            got = 1'b1;
                        end
                    end
                    P_WRITE:
                    begin
                        if (!in_alphabet(c))
                        begin
                            r = error_record(trtp_pkg::ERR_BAD_SYM);
                            got = 1'b1;
                        end
                        else
                        begin
                            write_sym = c;
                            parse_phase = P_SEP2;
                        end
                    end
                    P_SEP2:
                    begin
                        if (c != cfg_sep)
                        begin
                            r = error_record(trtp_pkg::ERR_NO_SEP);
                            got = 1'b1;
                        end
                        else
                            parse_phase = P_MOVE;
                    end
                    P_MOVE:
                    begin
                        // any minus in the move makes it negative
                        if (c == trtp_pkg::CHAR_MINUS)
                            move_neg = 1'b1;
                        else if (is_digit(c))
                            move_mag = 15'(add_digit(move_mag, c, MOVE_TOP));
                        else if (c == cfg_close)
                            parse_phase = P_RULE_DONE;
                        else
                        begin
                            r = error_record(trtp_pkg::ERR_NO_CLOSE);
                            got = 1'b1;
                        end
                    end
                    P_RULE_DONE:
                    begin
                        if (c != cfg_sep)
                        begin
                            r = error_record(trtp_pkg::ERR_NO_SEP);
                            got = 1'b1;
                        end
                        else
                        begin
                            r = rule_record();
                            got = 1'b1;
                            clear_rule();
                            parse_phase = P_OPEN;
                        end
                    end
                    default:
                    begin
                        if (c != cfg_open)
                        begin
                            r = error_record(trtp_pkg::ERR_NO_OPEN);
                            got = 1'b1;
                        end
                        else
                        begin
                            clear_rule();
                            parse_phase = P_LETTER1;
                        end
                    end
                endcase
            end
        end
    endtask

    // ---------------- registers ----------------

    task automatic write_reg(input logic [trtp_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [63:0] d);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= d;
        case (idx)
            trtp_pkg::REG_OPEN:  cfg_open = d[7:0];
            trtp_pkg::REG_CLOSE: cfg_close = d[7:0];
            trtp_pkg::REG_SEP:   cfg_sep = d[7:0];
            trtp_pkg::REG_CONN:  cfg_conn = d[7:0];
            trtp_pkg::REG_MASK0: cfg_alpha[0] = d;
            trtp_pkg::REG_MASK1: cfg_alpha[1] = d;
            trtp_pkg::REG_MASK2: cfg_alpha[2] = d;
            trtp_pkg::REG_MASK3: cfg_alpha[3] = d;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input char_setting_e s);
        logic [7:0]  o, c, sp, cn;
        logic [63:0] m [4];
        o  = trtp_pkg::OPEN_RST;
        c  = trtp_pkg::CLOSE_RST;
        sp = trtp_pkg::SEP_RST;
        cn = trtp_pkg::CONN_RST;
        for (int i = 0; i < 4; i++)
            m[i] = {$urandom, $urandom};
        case (s)
            SET_DEFAULT:
            begin
                m[1] = m[1] | (64'd1 << SYM_A[5:0]) | (64'd1 << SYM_B[5:0]);
                m[2] = '0;
                m[3] = '0;
            end
            SET_EXTREME:
            begin
                o  = 8'd0;
                c  = 8'd255;
                sp = 8'd1;
                cn = 8'd254;
                for (int i = 0; i < 4; i++)
                    m[i] = '1;
            end
            SET_BRACKETS:
            begin
                o  = "[";
                c  = "]";
                sp = ";";
                cn = ":";
                for (int i = 0; i < 4; i++)
                    m[i] = m[i] & {$urandom, $urandom};
            end
            SET_PLUS_SEP:
            begin
                // separator collides with the accept mark
                sp = trtp_pkg::CHAR_PLUS;
                cn = trtp_pkg::CHAR_ZERO;
            end
            SET_DIGIT_MARKS:
            begin
                // digits win over separator and close
                sp = "7";
                c  = "5";
            end
            SET_RANDOM:
            begin
                o  = 8'($urandom_range(0, 255));
                c  = 8'($urandom_range(0, 255));
                sp = 8'($urandom_range(0, 255));
                cn = 8'($urandom_range(0, 255));
            end
            default:
            begin
                m[0] = '0;
                m[1] = '0;
                m[2] = '1;
            end
        endcase
        write_reg(trtp_pkg::REG_OPEN, {56'd0, o});
        write_reg(trtp_pkg::REG_CLOSE, {56'd0, c});
        write_reg(trtp_pkg::REG_SEP, {56'd0, sp});
        write_reg(trtp_pkg::REG_CONN, {56'd0, cn});
        write_reg(trtp_pkg::REG_MASK0, m[0]);
        write_reg(trtp_pkg::REG_MASK1, m[1]);
        write_reg(trtp_pkg::REG_MASK2, m[2]);
        write_reg(trtp_pkg::REG_MASK3, m[3]);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // ---------------- text generation ----------------

    task automatic add_raw(input logic [7:0] c, input logic e);
        text_item_t t;
        t.code = c;
        t.eot  = e;
        text_buf.push_back(t);
    endtask

    // character with an occasional newline after it
    task automatic add(input logic [7:0] c);
        add_raw(c, 1'b0);
        if ($urandom_range(0, 24) == 0)
            add_raw(trtp_pkg::CHAR_NEWLINE, 1'b0);
    endtask

    task automatic add_end();
        add_raw(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_raw(s[i], 1'b0);
    endtask

    task automatic flush_text();
        foreach (text_buf[i])
            text_chars.push_back(text_buf[i]);
        text_buf.delete();
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(trtp_pkg::CHAR_UPPER_A + r) :
                          8'(trtp_pkg::CHAR_LOWER_A + (r - 26));
    endfunction

    function automatic logic [7:0] pick_symbol();
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < 64; i++)
        begin
            c = 8'($urandom_range(0, 255));
            if (in_alphabet(c) && c != trtp_pkg::CHAR_NEWLINE)
                return c;
        end
        return c;
    endfunction

    // empty, short, long or saturating digit string
    task automatic add_number();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 10) ? 0 :
            (r < 60) ? $urandom_range(1, 3) :
            (r < 85) ? $urandom_range(4, 5) : $urandom_range(6, 8);
        repeat (n)
            add(8'(trtp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic add_rule();
        int r;
        add(cfg_open);
        add(pick_letter());
        add_number();
        add(cfg_sep);
        add(pick_symbol());
        add(cfg_close);
        add(cfg_conn);
        add(cfg_open);
        add(pick_letter());
        r = $urandom_range(0, 99);
        if (r < 15)
            add(trtp_pkg::CHAR_PLUS);
        else if (r < 30)
            add(trtp_pkg::CHAR_MINUS);
        else
            add_number();
        add(cfg_sep);
        add(pick_symbol());
        add(cfg_sep);
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            add(trtp_pkg::CHAR_MINUS);
            add_number();
        end
        else if (r < 48)
        begin
            add_number();
            add(trtp_pkg::CHAR_MINUS);
            add(trtp_pkg::CHAR_MINUS);
        end
        else
            add_number();
        add(cfg_close);
    endtask

    // one text: mostly well-formed rules, some broken or pure noise
    task automatic make_text(inout int count);
        int r, n, pos;
        text_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                add_raw(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            n = (r < 12) ? 0 : $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add(cfg_sep);
                add_rule();
            end
            if ($urandom_range(0, 9) == 0)
                add(cfg_sep);
            r = $urandom_range(0, 99);
            if (text_buf.size() > 0 && r < 35)
            begin
                pos = $urandom_range(0, text_buf.size() - 1);
                if (r < 20)
                    text_buf[pos].code = 8'($urandom_range(0, 255));
                else
                    while (text_buf.size() > pos + 1)
                        void'(text_buf.pop_back());
            end
        end
        add_end();
        count += text_buf.size();
        flush_text();
    endtask

    // sender stops until every result is back and the block has settled
    task automatic wait_drained();
        while (text_chars.size() != 0 || push || parsed_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // idle length: mostly short, a few long, sometimes a calm stretch
    task automatic pick_idle(inout int calm, output int gap);
        int r;
        gap = 0;
        if (calm > 0)
            calm--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                calm = $urandom_range(30, 120);
            else if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // ---------------- input side ----------------

    // transfer accepted: predict its result
    always @(posedge clk)
    begin
        bit                got;
        trtp_pkg::result_t r;
        took = 1'b0;
        if (rst_n && push && !full)
        begin
            took = 1'b1;
            parse_char(ch, end_of_text, got, r);
            if (got)
                parsed_records.push_back(r);
        end
    end

    // driver
    always @(negedge clk)
    begin
        text_item_t item;
        if (!rst_n)
            push <= 1'b0;
        else if (push && !took)
        begin
            // hold until transfer
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            push <= 1'b0;
        end
        else if (text_chars.size() > 0)
        begin
            item = text_chars.pop_front();
            push        <= 1'b1;
            ch          <= item.code;
            end_of_text <= item.eot;
            pick_idle(send_calm, gap_left);
        end
        else
            push <= 1'b0;
    end

    // ---------------- result side ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            pick_idle(recv_calm, stall_left);
        end
    end

    // monitor: compare each result transfer with the oldest parsed record
    always @(posedge clk)
    begin
        trtp_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (parsed_records.size() == 0)
                report_mismatch("result with nothing due, kind", kind, 0);
            else
            begin
                want = parsed_records.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (from_state !== want.from_state)
                    report_mismatch("from_state", from_state, want.from_state);
                if (read_symbol !== want.read_symbol)
                    report_mismatch("read_symbol", read_symbol, want.read_symbol);
                if (to_state !== want.to_state)
                    report_mismatch("to_state", to_state, want.to_state);
                if (target_kind !== want.target_kind)
                    report_mismatch("target_kind", target_kind, want.target_kind);
                if (write_symbol !== want.write_symbol)
                    report_mismatch("write_symbol", write_symbol, want.write_symbol);
                if (head_move !== want.head_move)
                    report_mismatch("head_move", head_move[15:0], want.head_move);
                if (error_code !== want.error_code)
                    report_mismatch("error_code", error_code, want.error_code);
                if (error_position !== want.error_position)
                    report_mismatch("error_position", error_position, want.error_position);
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int count;
        bit paused;
        cfg_open  = trtp_pkg::OPEN_RST;
        cfg_close = trtp_pkg::CLOSE_RST;
        cfg_sep   = trtp_pkg::SEP_RST;
        cfg_conn  = trtp_pkg::CONN_RST;
        for (int i = 0; i < 4; i++)
            cfg_alpha[i] = '0;
        clear_text();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: empty text, then end right after an open
        add_end();
        add_string("(");
        add_end();
        flush_text();
        wait_drained();

        // saturating numbers, accept mark, newline, negative move;
        // then empty numbers, reject mark, repeated minus, trailing separator
        apply_setting(SET_DEFAULT);
        add_string("(z9999\n9,a)>(Q+,b,-99999)");
        add_end();
        add_string("(a,a)>(b-,a,--0),");
        add_end();
        flush_text();
        wait_drained();

        // random texts under each register setting
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            apply_setting(char_setting_e'(s));
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_CHARS)
            begin
                make_text(count);
                if (!paused && count >= PHASE_CHARS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0 && parsed_records.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/trtp_pkg.sv
hdl/trtp_fifo.sv
hdl/trtp_front.sv
hdl/trtp_back.sv
hdl/transition_rule_text_parser.sv
tb/testbench.sv
